// ===== rtl/core/utf8d_pkg.sv =====
// shared types and constants for the utf-8 stream decoder
// no dependencies

package utf8d_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned LEFT_W = 2;

    // byte class masks and match patterns
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;

    // continuation counts armed by each lead byte
    localparam logic [LEFT_W-1:0] LEFT_NONE = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    typedef struct packed {
        logic [LEFT_W-1:0] bytes_left;
        logic [CP_W-1:0]   partial_point;
    } t_dec_state;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            decode_error;
    } t_dec_result;

    // status of the output queue as seen by the decode stage
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== rtl/core/utf8_stream_decoder_top.sv =====
// top level of the lenient utf-8 stream decoder
// depends on utf8d_pkg, utf8d_step, utf8d_out_q
//
// usage
//   input channel: one raw byte per transfer on i_in_byte, qualified by
//   i_valid and held off by o_stall. output channel: one decoded code
//   point per transfer on o_code_point / o_decode_error, qualified by
//   o_valid and held off by i_stall.
//   a byte that ends a sequence, an ascii byte or a malformed byte gives
//   exactly one result; lead bytes and inner continuation bytes give none.
//   the byte that completes a result is held in the input register, then
//   its result is written to the result queue and offered from there.
//   throughput: one byte per cycle while o_stall is low, set by the
//   combinational state update in the decode step; the two-entry result
//   queue lets a byte be taken while a finished result still waits.
//   reset (i_rst_n low, synchronous): sequence state cleared to "awaiting
//   lead byte", input register and result queue emptied.
//   when the receiver stalls, results pile up in the queue; once it is
//   full and the pending byte would produce a result, o_stall rises and
//   holds the input until a slot frees.

module utf8_stream_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_in_byte,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [utf8d_pkg::CP_W-1:0]    o_code_point,
    output logic                          o_decode_error
);
    import utf8d_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // running sequence state
    t_dec_state r_state;
    t_dec_state n_state;

    logic        has_result;
    t_dec_result result;
    t_dec_result q_out;
    t_q_status   q_status;
    logic        advance;
    logic        take;

    utf8d_step u_step (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .o_state      (n_state),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // the pending byte retires unless it needs a queue slot and none is free
    assign advance = r_in_valid && !(has_result && q_status.full);
    assign o_stall = r_in_valid && !advance;
    assign take    = i_valid && !o_stall;

    utf8d_out_q u_out_q (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (advance && has_result),
        .i_data   (result),
        .o_status (q_status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (q_out)
    );

    assign o_code_point   = q_out.code_point;
    assign o_decode_error = q_out.decode_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
        end else begin
            // input register refills on a transfer, drains when it retires
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_byte <= i_in_byte;
        end
    end

endmodule

// ===== rtl/core/utf8d_step.sv =====
// combinational decode of one byte against the running sequence state
// depends on utf8d_pkg

module utf8d_step (
    input  utf8d_pkg::t_dec_state          i_state,
    input  logic [utf8d_pkg::BYTE_W-1:0]   i_byte,
    output utf8d_pkg::t_dec_state          o_state,
    output logic                           o_has_result,
    output utf8d_pkg::t_dec_result         o_result
);
    import utf8d_pkg::*;

    logic [LEFT_W-1:0] left_dec;

    assign left_dec = i_state.bytes_left - LEFT_ONE;

    always_comb begin
        o_state      = i_state;
        o_has_result = 1'b0;
        o_result     = '0;
        if (i_state.bytes_left == LEFT_NONE) begin
            if ((i_byte & ASCII_MASK) != ASCII_MASK) begin
                o_has_result        = 1'b1;
                o_result.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte};
            end else if ((i_byte & LEAD2_MASK) == LEAD2_PAT) begin
                o_state.partial_point = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                o_state.bytes_left    = LEFT_ONE;
            end else if ((i_byte & LEAD3_MASK) == LEAD3_PAT) begin
                o_state.partial_point = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                o_state.bytes_left    = LEFT_TWO;
            end else if ((i_byte & LEAD4_MASK) == LEAD4_PAT) begin
                o_state.partial_point = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                o_state.bytes_left    = LEFT_THREE;
            end else begin
                // bare continuation or 0xf8 and above
                o_has_result          = 1'b1;
                o_result.decode_error = 1'b1;
            end
        end else if ((i_byte & CONT_MASK) != CONT_PAT) begin
            // broken sequence, byte is swallowed
            o_state               = '0;
            o_has_result          = 1'b1;
            o_result.decode_error = 1'b1;
        end else if (left_dec == LEFT_NONE) begin
            o_state             = '0;
            o_has_result        = 1'b1;
            o_result.code_point = {i_state.partial_point[CP_W-7:0], i_byte[5:0]};
        end else begin
            o_state.partial_point = {i_state.partial_point[CP_W-7:0], i_byte[5:0]};
            o_state.bytes_left    = left_dec;
        end
    end

endmodule

// ===== rtl/core/utf8d_out_q.sv =====
// two-entry result queue that decouples the decoder from the output stall
// depends on utf8d_pkg

module utf8d_out_q (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  utf8d_pkg::t_dec_result  i_data,
    output utf8d_pkg::t_q_status    o_status,
    output logic                    o_valid,
    input  logic                    i_stall,
    output utf8d_pkg::t_dec_result  o_data
);
    import utf8d_pkg::*;

    t_dec_result r_mem [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign pop            = (r_count != 2'd0) && !i_stall;
    assign o_valid        = (r_count != 2'd0);
    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
